FILE: design/assert_macros.svh
// Assertion macros for the formatter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define PCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/pcf_pkg.sv
`default_nettype none
package pcf_pkg;

    localparam int unsigned CNT_W = 31;
    localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0]  fmt_byte;
        logic [63:0] arg_value;
    } t_in;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             last;
        logic [CNT_W-1:0] total_count;
    } t_out;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_FETCH = 4'd0;
    localparam t_pc PC_DISP  = 4'd1;
    localparam t_pc PC_LIT   = 4'd2;
    localparam t_pc PC_CHR   = 4'd3;
    localparam t_pc PC_NEG   = 4'd4;
    localparam t_pc PC_MUL   = 4'd5;
    localparam t_pc PC_DREM  = 4'd6;
    localparam t_pc PC_POP   = 4'd7;
    localparam t_pc PC_P0    = 4'd8;
    localparam t_pc PC_PX    = 4'd9;
    localparam t_pc PC_HEX   = 4'd10;

    typedef enum logic [2:0] {
        DP_NONE, DP_CAPTURE, DP_LOAD, DP_NEG, DP_MUL, DP_DREM, DP_HEX, DP_POP
    } t_dp;

    typedef enum logic [1:0] {
        SRC_BYTE, SRC_ARG, SRC_CONST, SRC_DIGIT
    } t_src;

    typedef enum logic [1:0] {
        LAST_NO, LAST_YES, LAST_DIGIT
    } t_last;

    typedef enum logic [2:0] {
        J_SEQ, J_GOTO, J_DISP, J_BRANCH, J_REPEAT
    } t_jmp;

    typedef enum logic [1:0] {
        MODE_DEC, MODE_HEX_LO, MODE_HEX_UP
    } t_mode;

    typedef struct packed {
        t_dp        dp;
        logic       emit;
        t_src       src;
        logic [7:0] konst;
        t_last      lst;
        t_jmp       jmp;
        t_pc        target;
    } t_uword;

    typedef struct packed {
        logic       go;
        t_dp        dp;
        logic       emit;
        t_src       src;
        logic [7:0] konst;
        t_last      lst;
        t_mode      mode;
        logic       wide;
    } t_ctrl;

    typedef struct packed {
        logic       more;
        logic       can_emit;
        logic [7:0] fmt_byte;
        logic       neg;
    } t_stat;

    typedef struct packed {
        t_pc   target;
        logic  pending;
        t_mode mode;
        logic  wide;
    } t_disp;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{dp: DP_NONE, emit: 1'b0, src: SRC_CONST, konst: CH_NUL, lst: LAST_NO,
              jmp: J_GOTO, target: PC_FETCH};
        case (pc)
            PC_FETCH: begin
                w.dp  = DP_CAPTURE;
                w.jmp = J_SEQ;
            end
            PC_DISP: begin
                w.dp  = DP_LOAD;
                w.jmp = J_DISP;
            end
            PC_LIT: begin
                w.emit = 1'b1;
                w.src  = SRC_BYTE;
                w.lst  = LAST_YES;
            end
            PC_CHR: begin
                w.emit = 1'b1;
                w.src  = SRC_ARG;
                w.lst  = LAST_YES;
            end
            PC_NEG: begin
                w.dp    = DP_NEG;
                w.emit  = 1'b1;
                w.konst = CH_MINUS;
                w.jmp   = J_SEQ;
            end
            PC_MUL: begin
                w.dp  = DP_MUL;
                w.jmp = J_SEQ;
            end
            PC_DREM: begin
                w.dp     = DP_DREM;
                w.jmp    = J_BRANCH;
                w.target = PC_MUL;
            end
            PC_POP: begin
                w.dp     = DP_POP;
                w.emit   = 1'b1;
                w.src    = SRC_DIGIT;
                w.lst    = LAST_DIGIT;
                w.jmp    = J_REPEAT;
                w.target = PC_FETCH;
            end
            PC_P0: begin
                w.emit  = 1'b1;
                w.konst = CH_ZERO;
                w.jmp   = J_SEQ;
            end
            PC_PX: begin
                w.emit  = 1'b1;
                w.konst = CH_X_LO;
                w.jmp   = J_SEQ;
            end
            PC_HEX: begin
                w.dp     = DP_HEX;
                w.jmp    = J_REPEAT;
                w.target = PC_POP;
            end
            default: begin
                w.jmp = J_GOTO;
            end
        endcase
        return w;
    endfunction

    function automatic t_disp decode(input logic [7:0] b, input logic pending,
                                     input logic neg);
        t_disp d;
        d = '{target: PC_FETCH, pending: 1'b0, mode: MODE_DEC, wide: 1'b0};
        if (b == CH_NUL) begin
            d.pending = pending;
        end else if (!pending) begin
            if (b == CH_PCT) begin
                d.pending = 1'b1;
            end else begin
                d.target = PC_LIT;
            end
        end else begin
            case (b)
                CH_C:       d.target = PC_CHR;
                CH_D, CH_I: d.target = neg ? PC_NEG : PC_MUL;
                CH_U:       d.target = PC_MUL;
                CH_X_LO: begin
                    d.target = PC_HEX;
                    d.mode   = MODE_HEX_LO;
                end
                CH_X_UP: begin
                    d.target = PC_HEX;
                    d.mode   = MODE_HEX_UP;
                end
                CH_P: begin
                    d.target = PC_P0;
                    d.mode   = MODE_HEX_LO;
                    d.wide   = 1'b1;
                end
                CH_PCT:     d.target = PC_LIT;
                default:    d.target = PC_FETCH;
            endcase
        end
        return d;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] dg, input t_mode m);
        logic [7:0] c;
        if (m == MODE_DEC || dg < 4'd10) begin
            c = CH_ZERO + {4'd0, dg};
        end else if (m == MODE_HEX_UP) begin
            c = CH_A_UP + {4'd0, dg} - 8'd10;
        end else begin
            c = CH_A_LO + {4'd0, dg} - 8'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/pcf_useq.sv
`default_nettype none
module pcf_useq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  pcf_pkg::t_stat     i_stat,
    output pcf_pkg::t_ctrl     o_ctrl,
    output logic               o_stall
);
    import pcf_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    logic   r_pending;
    t_uword uw;
    t_disp  dsp;
    logic   go;

    assign uw  = ucode(r_pc);
    assign dsp = decode(i_stat.fmt_byte, r_pending, i_stat.neg);

    always_comb begin
        if (uw.dp == DP_CAPTURE) begin
            go = i_valid;
        end else if (uw.emit) begin
            go = i_stat.can_emit;
        end else begin
            go = 1'b1;
        end
    end

    always_comb begin
        case (uw.jmp)
            J_SEQ:    n_pc = r_pc + 4'd1;
            J_GOTO:   n_pc = uw.target;
            J_DISP:   n_pc = dsp.target;
            J_BRANCH: n_pc = i_stat.more ? uw.target : r_pc + 4'd1;
            J_REPEAT: n_pc = i_stat.more ? r_pc : uw.target;
            default:  n_pc = PC_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_FETCH;
            r_pending <= 1'b0;
        end else if (go) begin
            r_pc <= n_pc;
            if (uw.jmp == J_DISP) begin
                r_pending <= dsp.pending;
            end
        end
    end

    assign o_stall = (uw.dp != DP_CAPTURE);

    assign o_ctrl = '{go: go, dp: uw.dp, emit: uw.emit, src: uw.src, konst: uw.konst,
                      lst: uw.lst, mode: dsp.mode, wide: dsp.wide};

endmodule
`default_nettype wire

FILE: design/pcf_dpath.sv
`default_nettype none
module pcf_dpath (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  pcf_pkg::t_ctrl i_ctrl,
    input  pcf_pkg::t_in   i_data,
    input  wire logic      i_stall,
    output logic           o_valid,
    output pcf_pkg::t_out  o_data,
    output pcf_pkg::t_stat o_stat
);
    import pcf_pkg::*;

    logic [7:0]       r_byte;
    logic [63:0]      r_arg;
    logic [63:0]      r_val;
    logic [28:0]      r_q;
    logic [4:0]       r_len;
    logic [3:0]       r_scr [16];
    t_mode            r_mode;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] n_total;
    logic             r_out_valid;
    t_out             r_out;

    logic [63:0] mul_p;
    logic [31:0] q10;
    logic [31:0] rem;
    logic [3:0]  pop_idx;
    logic [3:0]  pop_dig;
    logic [7:0]  ch;
    logic        lst;
    logic        can_emit;
    logic        emit_go;
    logic        more;

    assign mul_p    = {32'd0, r_val[31:0]} * {32'd0, RECIP10};
    assign q10      = {r_q, 3'b000} + {2'b00, r_q, 1'b0};
    assign rem      = r_val[31:0] - q10;
    assign pop_idx  = r_len[3:0] - 4'd1;
    assign pop_dig  = r_scr[pop_idx];
    assign can_emit = !r_out_valid || !i_stall;
    assign emit_go  = i_ctrl.go && i_ctrl.emit;
    assign n_total  = (r_total == CNT_MAX) ? CNT_MAX : r_total + 31'd1;

    always_comb begin
        case (i_ctrl.dp)
            DP_DREM: more = (r_q != 29'd0);
            DP_HEX:  more = (r_val[63:4] != 60'd0) && (r_len < 5'd15);
            DP_POP:  more = (r_len != 5'd1);
            default: more = 1'b0;
        endcase
    end

    always_comb begin
        case (i_ctrl.src)
            SRC_BYTE:  ch = r_byte;
            SRC_ARG:   ch = r_arg[7:0];
            SRC_CONST: ch = i_ctrl.konst;
            SRC_DIGIT: ch = digit_char(pop_dig, r_mode);
            default:   ch = i_ctrl.konst;
        endcase
    end

    always_comb begin
        case (i_ctrl.lst)
            LAST_YES:   lst = 1'b1;
            LAST_DIGIT: lst = (r_len == 5'd1);
            default:    lst = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.go) begin
            case (i_ctrl.dp)
                DP_CAPTURE: begin
                    r_byte <= i_data.fmt_byte;
                    r_arg  <= i_data.arg_value;
                end
                DP_LOAD: begin
                    r_val  <= i_ctrl.wide ? r_arg : {32'd0, r_arg[31:0]};
                    r_mode <= i_ctrl.mode;
                end
                DP_NEG: begin
                    r_val <= {32'd0, 32'd0 - r_val[31:0]};
                end
                DP_MUL: begin
                    r_q <= mul_p[63:35];
                end
                DP_DREM: begin
                    r_scr[r_len[3:0]] <= rem[3:0];
                    r_val             <= {35'd0, r_q};
                end
                DP_HEX: begin
                    r_scr[r_len[3:0]] <= r_val[3:0];
                    r_val             <= {4'd0, r_val[63:4]};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 5'd0;
        end else if (i_ctrl.go) begin
            case (i_ctrl.dp)
                DP_LOAD:         r_len <= 5'd0;
                DP_DREM, DP_HEX: r_len <= r_len + 5'd1;
                DP_POP:          r_len <= r_len - 5'd1;
                default:         r_len <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_total     <= n_total;
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out <= '{out_byte: ch, last: lst, total_count: n_total};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_stat  = '{more: more, can_emit: can_emit, fmt_byte: r_byte, neg: r_arg[31]};

endmodule
`default_nettype wire

FILE: design/printf_conversion_formatter.sv
// Byte-serial printf formatter for integer conversions.
// Input channel: one format byte per beat with the argument alongside
// (i_valid, o_stall, i_data). Output channel: one character per beat with
// a last flag and the saturating running character count (o_valid,
// i_stall, o_data).
// An item is taken only while the microcode sits on its fetch step; the
// item then runs to completion before the next is taken.
// An item runs through fetch and dispatch, then a step for each fixed
// character (literal, c, %, minus sign, 0x), then a reciprocal multiply
// and a remainder step per decimal digit or a hex step per hex digit,
// then an emit step per digit.
// The first character appears in the output register in the cycle after
// its emit step. A stalled receiver holds the emit step in place, so the
// sequencer waits; a new character is loaded the same cycle the old
// one leaves.
// Reset clears the pending percent flag, the character count and the
// output valid, and returns the sequencer to its fetch step.
`default_nettype none
`include "assert_macros.svh"
module printf_conversion_formatter (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  pcf_pkg::t_in  i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output pcf_pkg::t_out o_data
);
    import pcf_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    pcf_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_stall (o_stall)
    );

    pcf_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_data  (i_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_stat  (stat)
    );

    `PCF_ASSERT_NEXT(a_capture_then_dispatch, i_clk, i_rst_n, i_valid && !o_stall, ctrl.dp == DP_LOAD)
    `PCF_ASSERT_NEXT(a_emit_fills_output, i_clk, i_rst_n, ctrl.go && ctrl.emit, o_valid)
    `PCF_ASSERT_SAME(a_count_nonzero, i_clk, i_rst_n, o_valid, o_data.total_count != '0)

endmodule
`default_nettype wire

FILE: sim/printf_conversion_formatter_tb.sv
`timescale 1ns / 1ps
module printf_conversion_formatter_tb;
    import pcf_pkg::*;

    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_Q = 8'h71;
    localparam int STUCK_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_PER_PHASE = 64;

    typedef struct {
        t_in beat;
        bit  drain;
    } t_fmt_beat;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    t_in  drv_data = '0;
    logic rcv_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    t_fmt_beat  fmt_beats[$];
    t_out       expected_chars[$];
    t_out       want_char;
    logic       pct_armed = 1'b0;
    logic [CNT_W-1:0] emitted_cnt = '0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         errors = 0;
    int         stuck_cycles = 0;
    int         idle_tab[4] = '{0, 61, 0, 13};
    int         stall_tab[4] = '{0, 0, 61, 13};
    logic [7:0] conv_letters[10] = '{CH_C, CH_D, CH_I, CH_U, CH_X_LO, CH_X_UP, CH_P,
                                     CH_PCT, CH_S, CH_Q};

    printf_conversion_formatter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (drv_valid),
        .o_stall (o_stall),
        .i_data  (drv_data),
        .o_valid (o_valid),
        .i_stall (rcv_stall),
        .o_data  (o_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic format_beat(input t_in beat);
        logic [7:0]  chars[$];
        logic [3:0]  dig[16];
        logic [63:0] val;
        logic [63:0] radix;
        logic [31:0] word;
        logic [7:0]  ch;
        bit          upper;
        int          n;
        t_out        res;
        word  = beat.arg_value[31:0];
        val   = '0;
        radix = '0;
        upper = 1'b0;
        n     = 0;
        if (beat.fmt_byte == CH_NUL) return;
        if (!pct_armed) begin
            if (beat.fmt_byte == CH_PCT) pct_armed = 1'b1;
            else chars.push_back(beat.fmt_byte);
        end else begin
            pct_armed = 1'b0;
            case (beat.fmt_byte)
                CH_C: chars.push_back(beat.arg_value[7:0]);
                CH_D, CH_I: begin
                    if (word[31]) begin
                        chars.push_back(CH_MINUS);
                        word = -word;
                    end
                    val   = {32'd0, word};
                    radix = 64'd10;
                end
                CH_U: begin
                    val   = {32'd0, word};
                    radix = 64'd10;
                end
                CH_X_LO: begin
                    val   = {32'd0, word};
                    radix = 64'd16;
                end
                CH_X_UP: begin
                    val   = {32'd0, word};
                    radix = 64'd16;
                    upper = 1'b1;
                end
                CH_P: begin
                    chars.push_back(CH_ZERO);
                    chars.push_back(CH_X_LO);
                    val   = beat.arg_value;
                    radix = 64'd16;
                end
                CH_PCT: chars.push_back(CH_PCT);
                default: ;
            endcase
        end
        if (radix != 0) begin
            do begin
                dig[n] = 4'(val % radix);
                val = val / radix;
                n++;
            end while (val != 0 && n < 16);
            while (n > 0) begin
                n--;
                if (dig[n] < 4'd10) ch = CH_ZERO + {4'd0, dig[n]};
                else ch = (upper ? CH_A_UP : CH_A_LO) + {4'd0, dig[n]} - 8'd10;
                chars.push_back(ch);
            end
        end
        foreach (chars[k]) begin
            if (emitted_cnt != CNT_MAX) emitted_cnt++;
            res.out_byte    = chars[k];
            res.last        = (k == chars.size() - 1);
            res.total_count = emitted_cnt;
            expected_chars.push_back(res);
        end
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic [63:0] a, input bit drain);
        t_fmt_beat p;
        p.beat.fmt_byte  = b;
        p.beat.arg_value = a;
        p.drain          = drain;
        fmt_beats.push_back(p);
    endtask

    function automatic logic [63:0] rand_arg();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = {v[63:32], 32'h8000_0000};
            2, 3: ;
            default: v = v >> $urandom_range(63);
        endcase
        return v;
    endfunction

    task automatic queue_directed();
        queue_beat(8'h41, rand_arg(), 1'b0);
        queue_beat(8'hFF, 64'h0, 1'b0);
        queue_beat(CH_NUL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_C, 64'hFFFF_FFFF_FFFF_FF5A, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_D, 64'h0, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_D, 64'hFFFF_FFFF_7FFF_FFFF, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b1);
        queue_beat(CH_I, 64'h0000_0000_8000_0000, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_U, 64'h0000_0000_FFFF_FFFF, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_X_LO, 64'hFFFF_FFFF_0000_0000, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_X_UP, 64'hFFFF_FFFF_ABCD_EF09, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_P, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_S, 64'h0000_0000_1234_5678, 1'b0);
        queue_beat(CH_PCT, 64'h0, 1'b0);
        queue_beat(CH_NUL, 64'h0, 1'b0);
        queue_beat(CH_U, 64'h0000_0000_0000_3039, 1'b0);
    endtask

    task automatic queue_random(input int count);
        int made;
        int sel;
        made = 0;
        queue_beat(CH_PCT, rand_arg(), 1'b1);
        queue_beat(conv_letters[$urandom_range(9)], rand_arg(), 1'b0);
        while (made < count) begin
            sel = $urandom_range(99);
            if (sel < 65) begin
                queue_beat(CH_PCT, rand_arg(), $urandom_range(29) == 0);
                queue_beat(conv_letters[$urandom_range(9)], rand_arg(), 1'b0);
                made += 2;
            end else if (sel < 85) begin
                queue_beat(8'($urandom_range(255, 1)), rand_arg(), 1'b0);
                made++;
            end else if (sel < 92) begin
                queue_beat(CH_NUL, rand_arg(), 1'b0);
            end else begin
                queue_beat(CH_PCT, rand_arg(), 1'b0);
                queue_beat(CH_NUL, rand_arg(), 1'b0);
                queue_beat(8'($urandom_range(255, 1)), rand_arg(), 1'b0);
                made += 2;
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
            drv_data  <= '0;
        end else begin
            if (drv_valid && !o_stall) format_beat(drv_data);
            if (!drv_valid || !o_stall) begin
                if (fmt_beats.size() != 0 &&
                    !(fmt_beats[0].drain && expected_chars.size() != 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    drv_data  <= fmt_beats[0].beat;
                    drv_valid <= 1'b1;
                    fmt_beats.pop_front();
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rcv_stall <= 1'b0;
        end else begin
            if (o_valid && !rcv_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte %h last %b count %0d",
                                              o_data.out_byte, o_data.last,
                                              o_data.total_count));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (o_data.out_byte !== want_char.out_byte)
                        report_mismatch($sformatf("out_byte got %h want %h",
                                                  o_data.out_byte, want_char.out_byte));
                    if (o_data.last !== want_char.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  o_data.last, want_char.last));
                    if (o_data.total_count !== want_char.total_count)
                        report_mismatch($sformatf("total_count got %0d want %0d",
                                                  o_data.total_count, want_char.total_count));
                end
            end
            rcv_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            stuck_cycles <= 0;
        end else if ((drv_valid && !o_stall) || (o_valid && !rcv_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            @(negedge clk);
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            if (ph == 0) queue_directed();
            queue_random(RANDOM_PER_PHASE);
            while (fmt_beats.size() != 0 || drv_valid || expected_chars.size() != 0)
                @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
